[hw/rtl/bfa_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the bitmap frame allocator.
// No dependencies; imported by the allocator core and the divider.
package bfa_pkg;

  localparam int ADDR_W    = 22;  // byte address fields
  localparam int COUNT_W   = 11;  // frame count field
  localparam int STATUS_W  = 2;
  localparam int WORD_BITS = 8;   // frames held in one bitmap word

  // request kinds
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NORUN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

endpackage

[hw/rtl/bitmap_frame_allocator_core.sv]
`timescale 1ns / 1ps
// Bitmap first-fit page frame allocator. One request in flight, one response per request.
// Allocate: word scan (one bitmap word a cycle), read-modify-write sweep over the run's
// words, then a multiply step to scale the address. No fit gives ST_NORUN after the
// whole scan; an oversized count gives ST_NORUN and a zero count ST_BAD, both unscanned.
// Free: reciprocal-multiply divide then one read-modify-write (skipped on a bad address).
// Reset: clearing pass over all DEPTH words (128 by default), no request taken meanwhile.
module bitmap_frame_allocator_core import bfa_pkg::*; #(
  parameter int FRAME_COUNT = 1024,
  parameter int FRAME_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                func,
  input  logic [COUNT_W-1:0]  frame_count,
  input  logic [ADDR_W-1:0]   free_address,
  // response channel
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [ADDR_W-1:0]   run_address
);

  // Bitmap geometry: words of WORD_BITS frames, tail bits of the last word act as used.
  // Next request is taken the cycle after the response register loads.
  localparam int DEPTH = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(WORD_BITS);
  localparam int IW    = AW + PW;              // frame index
  localparam int PTR_W = AW + 1;               // word pointer, can reach DEPTH
  localparam int RW    = COUNT_W + 1;          // running free-run length
  localparam int SW    = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;
  localparam logic [WORD_BITS-1:0] PAD_MASK =
    ~({WORD_BITS{1'b1}} >> (DEPTH * WORD_BITS - FRAME_COUNT));

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_DIV     = 9'b000000100,
    S_FREE_RD = 9'b000001000,
    S_FREE_WR = 9'b000010000,
    S_SCAN    = 9'b000100000,
    S_MARK    = 9'b001000000,
    S_MUL     = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [PTR_W-1:0]    ptr;         // clear / scan / mark word pointer
  logic                rd_pend;     // a RAM read was issued last cycle
  logic [AW-1:0]       rd_word;     // word address of that read
  logic [RW-1:0]       run;         // free frames ending at the previous word
  logic [COUNT_W-1:0]  want;
  logic [IW-1:0]       first_frame; // run start, or the frame to free
  logic [IW-1:0]       last_frame;
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;

  logic                req_take;
  logic                rsp_load;
  logic                count_bad;
  logic                count_long;

  // bitmap RAM
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // address divider
  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] div_quot;
  logic              quot_bad;

  // scan datapath
  logic [WORD_BITS-1:0] used_eff;
  logic [RW-1:0]        run_acc;
  logic                 hit;
  logic [PW-1:0]        hit_pos;
  logic [IW-1:0]        end_frame;
  logic [IW-1:0]        first_calc;
  logic                 last_word;
  logic                 scan_re;

  // mark datapath
  logic [AW-1:0]        first_word;
  logic [AW-1:0]        end_word;
  logic [WORD_BITS-1:0] mark_mask;
  logic                 mark_re;
  logic [WORD_BITS-1:0] free_mask;

  bfa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bfa_div #(
    .DIVISOR(FRAME_BYTES)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(free_address),
    .done    (div_done),
    .quotient(div_quot)
  );

  assign req_stall  = (state != S_IDLE);
  assign req_take   = req_valid && !req_stall;
  assign rsp_load   = (state == S_DONE) && (!rsp_valid || !rsp_stall);
  assign count_bad  = (frame_count == '0);
  assign count_long = 32'(frame_count) > FRAME_COUNT;
  assign div_start  = req_take && (func == FUNC_FREE);
  assign quot_bad   = 32'(div_quot) >= FRAME_COUNT;

  // --- scan: extend the free run across one word, look for the first end of a long enough run
  assign last_word = (rd_word == AW'(DEPTH - 1));
  assign used_eff  = ram_rdata | (last_word ? PAD_MASK : '0);

  always_comb begin
    run_acc = run;
    hit     = 1'b0;
    hit_pos = '0;
    for (int p = 0; p < WORD_BITS; p++) begin
      if (used_eff[p]) begin
        run_acc = '0;
      end else begin
        run_acc = run_acc + 1'b1;
      end
      if (!used_eff[p] && !hit && run_acc == RW'(want)) begin
        hit     = 1'b1;
        hit_pos = PW'(p);
      end
    end
  end

  assign end_frame  = {rd_word, hit_pos};
  assign first_calc = IW'(SW'(end_frame) + SW'(1) - SW'(want));
  assign scan_re    = (state == S_SCAN) && (ptr < PTR_W'(DEPTH));

  // --- mark: set the run's bits word by word, keeping the neighbours in the end words
  assign first_word = first_frame[IW-1:PW];
  assign end_word   = last_frame[IW-1:PW];
  assign mark_re    = (state == S_MARK) && (ptr <= {1'b0, end_word});

  always_comb begin
    for (int p = 0; p < WORD_BITS; p++) begin
      mark_mask[p] = ((rd_word != first_word) || (PW'(p) >= first_frame[PW-1:0])) &&
                     ((rd_word != end_word)   || (PW'(p) <= last_frame[PW-1:0]));
    end
  end

  assign free_mask = ~(WORD_BITS'(1) << first_frame[PW-1:0]);

  // --- RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_word;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = ptr[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr[AW-1:0];
      end
      S_SCAN: begin
        ram_re = scan_re;
      end
      S_MARK: begin
        ram_re    = mark_re;
        ram_we    = rd_pend;
        ram_wdata = ram_rdata | mark_mask;
      end
      S_FREE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = first_word;
      end
      S_FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = first_word;
        ram_wdata = ram_rdata & free_mask;
      end
      default: begin
      end
    endcase
  end

  // --- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (ptr == PTR_W'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_take) begin
          priority if (func == FUNC_FREE) state_next = S_DIV;
          else if (count_bad || count_long) state_next = S_DONE;
          else state_next = S_SCAN;
        end
      end
      S_DIV: begin
        if (div_done) state_next = quot_bad ? S_DONE : S_FREE_RD;
      end
      S_FREE_RD: state_next = S_FREE_WR;
      S_FREE_WR: state_next = S_DONE;
      S_SCAN: begin
        priority if (rd_pend && hit) state_next = S_MARK;
        else if (rd_pend && last_word) state_next = S_DONE;
      end
      S_MARK: begin
        if (rd_pend && rd_word == end_word) state_next = S_MUL;
      end
      S_MUL: state_next = S_DONE;
      S_DONE: begin
        if (rsp_load) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ptr       <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;

      // response register: filled from the result, drained by the consumer
      if (rsp_load) begin
        rsp_valid   <= 1'b1;
        status      <= res_status;
        run_address <= res_addr;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + 1'b1;
        end
        S_IDLE: begin
          if (req_take) begin
            want     <= frame_count;
            res_addr <= '0;
            ptr      <= '0;
            rd_pend  <= 1'b0;
            run      <= '0;
            priority if (func == FUNC_ALLOC && count_bad) res_status <= ST_BAD;
            else if (func == FUNC_ALLOC && count_long) res_status <= ST_NORUN;
            else res_status <= ST_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            first_frame <= div_quot[IW-1:0];
            res_status  <= quot_bad ? ST_BAD : ST_DONE;
          end
        end
        S_SCAN: begin
          rd_word <= ptr[AW-1:0];
          if (rd_pend) run <= run_acc;
          if (rd_pend && hit) begin
            // run found: restart the pointer at its first word for marking
            first_frame <= first_calc;
            last_frame  <= end_frame;
            ptr         <= {1'b0, first_calc[IW-1:PW]};
            rd_pend     <= 1'b0;
            res_status  <= ST_DONE;
          end else begin
            if (scan_re) ptr <= ptr + 1'b1;
            rd_pend <= scan_re;
            if (rd_pend && last_word) res_status <= ST_NORUN;
          end
        end
        S_MARK: begin
          if (mark_re) ptr <= ptr + 1'b1;
          rd_pend <= mark_re;
          rd_word <= ptr[AW-1:0];
        end
        S_MUL: begin
          res_addr <= ADDR_W'(first_frame * FRAME_BYTES);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[hw/rtl/bfa_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/bfa_div.sv]
`timescale 1ns / 1ps
// Divider by a fixed divisor: one registered reciprocal multiplication, quotient valid
// with done in the cycle after start. Depends on bfa_pkg.
module bfa_div import bfa_pkg::*; #(
  parameter int DIVISOR = 4096,
  localparam int LW  = $clog2(DIVISOR),
  localparam int SH  = ADDR_W + LW,
  localparam int MW  = ADDR_W + 1,
  localparam int PRW = ADDR_W + MW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  output logic              done,
  output logic [ADDR_W-1:0] quotient
);

  // ceil(2^SH / DIVISOR): exact floor division for every ADDR_W-bit dividend
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [PRW-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
    if (start) begin
      prod <= PRW'(dividend) * PRW'(RECIP);
    end
  end

  assign quotient = ADDR_W'(prod >> SH);

endmodule
